@@ rtl/bmhq_pkg.sv @@
`default_nettype none

package bmhq_pkg;

  localparam int HEAP_DEPTH  = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // shift command broadcast along the row of cells
  typedef struct packed {
    logic push;
    logic pop;
    val_t value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/bmhq_cell.sv @@
`default_nettype none

module bmhq_cell (
  input  logic                clk_i,
  input  bmhq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                prev_keep_i,
  input  bmhq_pkg::val_t      prev_val_i,
  input  bmhq_pkg::val_t      next_val_i,
  output logic                keep_o,
  output bmhq_pkg::val_t      val_o
);
  import bmhq_pkg::*;

  val_t val_q, val_d;

  // this entry stays put on a push when it is occupied and at least the new value
  assign keep_o = occ_i && (val_q >= ctrl_i.value);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.push) begin
      if (keep_o) begin
        val_d = val_q;
      end else if (prev_keep_i) begin
        val_d = ctrl_i.value;
      end else begin
        val_d = prev_val_i;
      end
    end else if (ctrl_i.pop) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

@@ rtl/binary_max_heap_queue_unit.sv @@
`default_nettype none

// Max-priority queue of up to 64 signed entries. An operation (push a value
// or pop the largest) is taken on any cycle with start high; busy stays low,
// so one operation can be issued every clock. The entries sit in a row of
// cells kept in descending order: a push makes every cell compare with the
// new value at once and the smaller ones shift one place down, a pop shifts
// the whole row one place up. The result of each operation appears with
// done_o for exactly one cycle on the next clock.
// The receiver cannot stall, so done_o must be captured when it is seen.
// A push to a full queue is dropped with status 1, a pop of an empty queue
// is ignored with status 2; top_value_o reads zero while the queue is empty.
module binary_max_heap_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [0:0]  opcode_i,
  input  logic signed [31:0] value_i,
  output logic        done_o,
  output logic signed [31:0] top_value_o,
  output logic [bmhq_pkg::CNT_W-1:0] count_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);
  import bmhq_pkg::*;

  cnt_t       count_q, count_d;
  status_e    status_q, status_d;
  logic       done_q;
  logic       take;
  logic       full, empty;
  cell_ctrl_t ctrl;

  val_t       cell_val  [HEAP_DEPTH];
  logic       cell_keep [HEAP_DEPTH];

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (count_q == cnt_t'(HEAP_DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    count_d    = count_q;
    status_d   = ST_OK;
    ctrl.push  = 1'b0;
    ctrl.pop   = 1'b0;
    ctrl.value = val_t'(value_i);
    if (op_e'(opcode_i) == OP_PUSH) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        ctrl.push = take;
        count_d   = cnt_t'(count_q + 1'b1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        ctrl.pop = take;
        count_d  = cnt_t'(count_q - 1'b1);
      end
    end
  end

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic occ;
    val_t prev_val, next_val;
    logic prev_keep;

    assign occ = (count_q > cnt_t'(i));

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_val  = ctrl.value;
    end else begin : g_body
      assign prev_keep = cell_keep[i-1];
      assign prev_val  = cell_val[i-1];
    end

    if (i == HEAP_DEPTH - 1) begin : g_tail
      assign next_val = ctrl.value;
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    bmhq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .prev_keep_i (prev_keep),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .keep_o      (cell_keep[i]),
      .val_o       (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      done_q <= take;
      if (take) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  assign done_o      = done_q;
  assign count_o     = count_q;
  assign is_empty_o  = empty;
  assign status_o    = status_q;
  assign top_value_o = empty ? 32'sd0 : 32'(cell_val[0]);

endmodule

`default_nettype wire

@@ rtl/bmhq_checker.sv @@
`default_nettype none

module bmhq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        done_o,
  input  logic signed [31:0] top_value_o,
  input  logic [bmhq_pkg::CNT_W-1:0] count_o,
  input  logic        is_empty_o,
  input  logic [1:0]  status_o
);
  import bmhq_pkg::*;

  // every accepted transfer yields exactly one result on the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result after accepted operation");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without accepted operation");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (top_value_o == 32'sd0))
    else $error("nonzero top on empty queue");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (count_o == CNT_W'(HEAP_DEPTH)))
    else $error("push dropped while not full");

endmodule

bind binary_max_heap_queue_unit bmhq_checker u_bmhq_checker (.*);

`default_nettype wire
